// ===== rtl/epcr_pkg.sv =====
// Shared constants and types for the elastic pair collision response block.
`timescale 1ns / 1ps

package epcr_pkg;

   localparam int MASS_W     = 16;
   localparam int VALUE_W    = 32;
   localparam int COMPS      = 4;
   localparam int MSUM_W     = MASS_W + 1;
   localparam int PROD_W     = MSUM_W + VALUE_W;
   localparam int NSUM_W     = MASS_W + VALUE_W + 3;
   localparam int MAG_W      = NSUM_W - 1;
   localparam int DIV_BPS    = 5;
   localparam int DIV_STAGES = (MAG_W + DIV_BPS - 1) / DIV_BPS;
   localparam int NUM_W      = DIV_STAGES * DIV_BPS;

   typedef struct packed {
      logic [MASS_W-1:0]  first_mass;
      logic [MASS_W-1:0]  second_mass;
      logic [VALUE_W-1:0] first_vel_x;
      logic [VALUE_W-1:0] first_vel_y;
      logic [VALUE_W-1:0] second_vel_x;
      logic [VALUE_W-1:0] second_vel_y;
      logic [VALUE_W-1:0] first_charge;
      logic [VALUE_W-1:0] second_charge;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] new_first_vel_x;
      logic [VALUE_W-1:0] new_first_vel_y;
      logic [VALUE_W-1:0] new_second_vel_x;
      logic [VALUE_W-1:0] new_second_vel_y;
      logic [VALUE_W-1:0] shared_charge;
      logic               saturated;
      logic               zero_mass_sum;
   } rsp_type;

   typedef struct packed {
      logic [MSUM_W-1:0]             msum;
      logic [COMPS-1:0][VALUE_W-1:0] vel;
      logic [VALUE_W-1:0]            half;
      logic                          zero;
   } side_type;

   typedef struct packed {
      side_type          side;
      logic [MSUM_W-1:0] diff;
      logic [MASS_W-1:0] m1;
      logic [MASS_W-1:0] m2;
   } prep_type;

   typedef struct packed {
      side_type                     side;
      logic [COMPS-1:0][PROD_W-1:0] pd;
      logic [COMPS-1:0][PROD_W-1:0] pm;
   } mult_type;

   typedef struct packed {
      side_type                     side;
      logic [COMPS-1:0]             neg;
      logic [COMPS-1:0][MSUM_W-1:0] rem;
      logic [COMPS-1:0][NUM_W-1:0]  num;
   } div_type;

endpackage

// ===== rtl/elastic_pair_collision_response.sv =====
// Pipelined elastic collision response, one particle pair per cycle unless stalled.
//
//   channel | ports                          | direction | payload
//   --------+--------------------------------+-----------+-------------------
//   request | req_valid req_ready req_data   | in        | epcr_pkg::req_type
//   response| rsp_valid rsp_ready rsp_data   | out       | epcr_pkg::rsp_type
//
// One item per cycle while rsp_ready does not stall the pipeline; the stages are:
// prepare, multiply, numerator, DIV_STAGES divider stages of DIV_BPS quotient
// bits each, and the saturating output register.
// Reset clears every stage valid bit; payload registers are not reset.
// Each stage holds while its successor is full and stalled, so bubbles close up
// and a stall on rsp_ready loses and repeats nothing.
`timescale 1ns / 1ps

module elastic_pair_collision_response (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  epcr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output epcr_pkg::rsp_type rsp_data
);

   localparam int DS   = epcr_pkg::DIV_STAGES;
   localparam int NSTG = DS + 4;
   localparam int VW   = epcr_pkg::VALUE_W;
   localparam int NW   = epcr_pkg::NUM_W;
   localparam int MW   = epcr_pkg::MSUM_W;
   localparam logic [NW-1:0] LIM_NEG = NW'(1) << (VW - 1);
   localparam logic [NW-1:0] LIM_POS = LIM_NEG - NW'(1);

   logic [NSTG-1:0] vld_ff, vld_in, rdy;

   epcr_pkg::prep_type prep_ff, prep_in;
   epcr_pkg::mult_type mult_ff, mult_in;
   epcr_pkg::div_type  dv_ff [0:DS];
   epcr_pkg::div_type  dv_in [0:DS];
   epcr_pkg::rsp_type  rsp_ff, rsp_in;

   // stage handshake
   always_comb begin
      rdy[NSTG-1] = !vld_ff[NSTG-1] || rsp_ready;
      for (int k = NSTG - 2; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
      vld_in[0] = rdy[0] ? req_valid : vld_ff[0];
      for (int k = 1; k < NSTG; k++) begin
         vld_in[k] = rdy[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   assign req_ready = rdy[0];
   assign rsp_valid = vld_ff[NSTG-1];
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // prepare: mass sum, mass difference, charge mean
   always_comb begin
      logic [VW:0] qs;
      qs = {req_data.first_charge[VW-1], req_data.first_charge}
         + {req_data.second_charge[VW-1], req_data.second_charge};
      prep_in.m1          = req_data.first_mass;
      prep_in.m2          = req_data.second_mass;
      prep_in.side.msum   = {1'b0, req_data.first_mass} + {1'b0, req_data.second_mass};
      prep_in.diff        = {1'b0, req_data.first_mass} - {1'b0, req_data.second_mass};
      prep_in.side.vel[0] = req_data.first_vel_x;
      prep_in.side.vel[1] = req_data.first_vel_y;
      prep_in.side.vel[2] = req_data.second_vel_x;
      prep_in.side.vel[3] = req_data.second_vel_y;
      prep_in.side.half   = qs[VW:1];
      prep_in.side.zero   = (prep_in.side.msum == '0);
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         prep_ff <= prep_in;
      end
   end

   // multiply
   always_comb begin
      logic signed [MW-1:0]                  sdiff, ndiff, sm1, sm2;
      logic signed [epcr_pkg::PROD_W-1:0]    p [0:7];
      sdiff = $signed(prep_ff.diff);
      ndiff = -sdiff;
      sm1   = $signed({1'b0, prep_ff.m1});
      sm2   = $signed({1'b0, prep_ff.m2});
      p[0]  = sdiff * $signed(prep_ff.side.vel[0]);
      p[1]  = sm2   * $signed(prep_ff.side.vel[2]);
      p[2]  = sdiff * $signed(prep_ff.side.vel[1]);
      p[3]  = sm2   * $signed(prep_ff.side.vel[3]);
      p[4]  = ndiff * $signed(prep_ff.side.vel[2]);
      p[5]  = sm1   * $signed(prep_ff.side.vel[0]);
      p[6]  = ndiff * $signed(prep_ff.side.vel[3]);
      p[7]  = sm1   * $signed(prep_ff.side.vel[1]);
      mult_in.side = prep_ff.side;
      for (int c = 0; c < epcr_pkg::COMPS; c++) begin
         mult_in.pd[c] = p[2*c];
         mult_in.pm[c] = p[2*c+1];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         mult_ff <= mult_in;
      end
   end

   // numerator sign and magnitude
   always_comb begin
      logic signed [epcr_pkg::NSUM_W-1:0] nsum;
      logic [epcr_pkg::NSUM_W-1:0]        amag;
      dv_in[0].side = mult_ff.side;
      for (int c = 0; c < epcr_pkg::COMPS; c++) begin
         nsum = epcr_pkg::NSUM_W'($signed(mult_ff.pd[c]))
              + (epcr_pkg::NSUM_W'($signed(mult_ff.pm[c])) <<< 1);
         amag = nsum[epcr_pkg::NSUM_W-1] ? -nsum : nsum;
         dv_in[0].neg[c] = nsum[epcr_pkg::NSUM_W-1];
         dv_in[0].rem[c] = '0;
         dv_in[0].num[c] = NW'(amag[epcr_pkg::MAG_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         dv_ff[0] <= dv_in[0];
      end
   end

   // restoring divider, DIV_BPS quotient bits per stage
   for (genvar g = 0; g < DS; g++) begin : g_div
      always_comb begin
         logic [MW:0]   t;
         logic [MW-1:0] r;
         logic [NW-1:0] n;
         dv_in[g+1].side = dv_ff[g].side;
         dv_in[g+1].neg  = dv_ff[g].neg;
         for (int c = 0; c < epcr_pkg::COMPS; c++) begin
            r = dv_ff[g].rem[c];
            n = dv_ff[g].num[c];
            for (int s = 0; s < epcr_pkg::DIV_BPS; s++) begin
               t = {r, n[NW-1]};
               n = n << 1;
               if (t >= {1'b0, dv_ff[g].side.msum}) begin
                  t    = t - {1'b0, dv_ff[g].side.msum};
                  n[0] = 1'b1;
               end
               r = t[MW-1:0];
            end
            dv_in[g+1].rem[c] = r;
            dv_in[g+1].num[c] = n;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[g+3]) begin
            dv_ff[g+1] <= dv_in[g+1];
         end
      end
   end

   // saturate, restore sign, select pass-through
   always_comb begin
      logic [NW-1:0]               lim, q;
      logic [epcr_pkg::COMPS-1:0]  sat;
      logic [VW-1:0]               res [0:3];
      for (int c = 0; c < epcr_pkg::COMPS; c++) begin
         lim    = dv_ff[DS].neg[c] ? LIM_NEG : LIM_POS;
         sat[c] = dv_ff[DS].num[c] > lim;
         q      = sat[c] ? lim : dv_ff[DS].num[c];
         res[c] = dv_ff[DS].neg[c] ? -q[VW-1:0] : q[VW-1:0];
         if (dv_ff[DS].side.zero) begin
            res[c] = dv_ff[DS].side.vel[c];
         end
      end
      rsp_in.new_first_vel_x  = res[0];
      rsp_in.new_first_vel_y  = res[1];
      rsp_in.new_second_vel_x = res[2];
      rsp_in.new_second_vel_y = res[3];
      rsp_in.shared_charge    = dv_ff[DS].side.half;
      rsp_in.saturated        = !dv_ff[DS].side.zero && (sat != '0);
      rsp_in.zero_mass_sum    = dv_ff[DS].side.zero;
   end

   always_ff @(posedge clock) begin
      if (rdy[NSTG-1]) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ===== rtl/epcr_checker.sv =====
// Port-level checker for the elastic pair collision response block and its bind.
`timescale 1ns / 1ps

module epcr_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input epcr_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input epcr_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response item changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_zero_nosat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_mass_sum |-> !rsp_data.saturated)
      else $error("saturated flagged on zero mass sum");

   a_sat_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturated |->
         rsp_data.new_first_vel_x == 32'h7fff_ffff
      || rsp_data.new_first_vel_x == 32'h8000_0000
      || rsp_data.new_first_vel_y == 32'h7fff_ffff
      || rsp_data.new_first_vel_y == 32'h8000_0000
      || rsp_data.new_second_vel_x == 32'h7fff_ffff
      || rsp_data.new_second_vel_x == 32'h8000_0000
      || rsp_data.new_second_vel_y == 32'h7fff_ffff
      || rsp_data.new_second_vel_y == 32'h8000_0000)
      else $error("saturated flagged with no clamped velocity");

endmodule

bind elastic_pair_collision_response epcr_checker u_epcr_checker (.*);
